[design/mrpc_pkg.sv]
// Package for the max relative pointwise change unit.
// Holds field widths, fixed-point settings, saturation limit and shared structs.
// No dependencies.
package mrpc_pkg;

  // Fixed-point settings
  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // Field widths
  localparam int IN_W   = 32;             // signed input fields
  localparam int CFG_W  = 31;             // min_denominator
  localparam int OUT_W  = 32;             // max_change, quotient width
  localparam int DIFF_W = IN_W + 1;       // |new - old| kept with a spare bit
  localparam int BASE_W = IN_W;           // max(|new_base|, |old_base|) <= 2^31

  // Dividend (diff << FRAC_BITS) split into the high part and the serial stream
  localparam int WIDE_W = DIFF_W + FRAC_BITS;
  localparam int REM0_W = WIDE_W - OUT_W;
  localparam int CNT_W  = $clog2(OUT_W);

  // Saturation
  localparam int SAT_W = (VALUE_BITS < OUT_W) ? VALUE_BITS : OUT_W;
  localparam logic [OUT_W-1:0] SAT_LIMIT = OUT_W'((64'd1 << SAT_W) - 64'd1);

  localparam logic [CFG_W-1:0] MIN_DEN_RESET = CFG_W'(1);

  // Operands after the front stage
  typedef struct packed {
    logic [DIFF_W-1:0] diff;
    logic [BASE_W-1:0] base;
    logic              last;
  } prep_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[design/mrpc_prep.sv]
// Front stage: absolute difference and larger base magnitude, registered.
// Depends on mrpc_pkg.
module mrpc_prep (
  input  logic                         clk,
  input  logic                         load,
  input  logic [mrpc_pkg::IN_W-1:0]    new_value,
  input  logic [mrpc_pkg::IN_W-1:0]    old_value,
  input  logic [mrpc_pkg::IN_W-1:0]    new_base,
  input  logic [mrpc_pkg::IN_W-1:0]    old_base,
  input  logic                         last_in_sweep,
  output mrpc_pkg::prep_t              prep
);
  import mrpc_pkg::*;

  logic signed [DIFF_W-1:0] nv_ext;
  logic signed [DIFF_W-1:0] ov_ext;
  logic signed [DIFF_W-1:0] d_fwd;
  logic signed [DIFF_W-1:0] d_rev;
  logic [BASE_W-1:0]        nb_mag;
  logic [BASE_W-1:0]        ob_mag;
  prep_t                    prep_r;
  prep_t                    prep_nxt;

  // Both difference directions in parallel, pick the non-negative one
  always_comb begin
    nv_ext = DIFF_W'(signed'(new_value));
    ov_ext = DIFF_W'(signed'(old_value));
    d_fwd  = nv_ext - ov_ext;
    d_rev  = ov_ext - nv_ext;
    nb_mag = new_base[IN_W-1] ? BASE_W'(-new_base) : new_base;
    ob_mag = old_base[IN_W-1] ? BASE_W'(-old_base) : old_base;
    prep_nxt.diff = d_fwd[DIFF_W-1] ? DIFF_W'(d_rev) : DIFF_W'(d_fwd);
    prep_nxt.base = (nb_mag > ob_mag) ? nb_mag : ob_mag;
    prep_nxt.last = last_in_sweep;
  end

  // Operand register, loaded on an accepted transaction
  always_ff @(posedge clk) begin
    if (load) begin
      prep_r <= prep_nxt;
    end
  end

  assign prep = prep_r;

endmodule

[design/mrpc_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on mrpc_pkg.
module mrpc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mrpc_pkg::OUT_W-1:0]    rem0,
  input  logic [mrpc_pkg::OUT_W-1:0]    stream,
  input  logic [mrpc_pkg::BASE_W-1:0]   divisor,
  output logic [mrpc_pkg::OUT_W-1:0]    quotient,
  output mrpc_pkg::div_stat_t           stat
);
  import mrpc_pkg::*;

  logic [OUT_W-1:0]  rem_r,  rem_nxt;
  logic [OUT_W-1:0]  shf_r,  shf_nxt;
  logic [OUT_W-1:0]  quo_r,  quo_nxt;
  logic [BASE_W-1:0] dvs_r,  dvs_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [OUT_W:0]    trial;
  logic              ge;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem_r, shf_r[OUT_W-1]};
    ge       = trial >= (OUT_W+1)'(dvs_r);
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = rem0;
      shf_nxt  = stream;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? OUT_W'(trial - (OUT_W+1)'(dvs_r)) : OUT_W'(trial);
      shf_nxt = {shf_r[OUT_W-2:0], 1'b0};
      quo_nxt = {quo_r[OUT_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(OUT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    shf_r <= shf_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[design/max_relative_pointwise_change_unit.sv]
// Max relative pointwise change over a sweep. A transaction that needs the ratio
// goes from acceptance to the result register through the front stage, 32 serial
// divider steps, done and update; a floor or saturated case skips the divider.
// One transaction at a time: no new one is accepted until the last one is through
// the update step, which on a sweep's last point waits for a free result register.
// Synchronous active-low reset: min_denominator = 1, running maximum = 0, no result.
module max_relative_pointwise_change_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [mrpc_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mrpc_pkg::IN_W-1:0]   in_new_value,
  input  logic [mrpc_pkg::IN_W-1:0]   in_old_value,
  input  logic [mrpc_pkg::IN_W-1:0]   in_new_base,
  input  logic [mrpc_pkg::IN_W-1:0]   in_old_base,
  input  logic                        in_last_in_sweep,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mrpc_pkg::OUT_W-1:0]  out_max_change
);
  import mrpc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_OPER = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state_r,     state_nxt;
  logic [CFG_W-1:0] min_den_r,   min_den_nxt;
  logic [OUT_W-1:0] max_r,       max_nxt;
  logic [OUT_W-1:0] change_r,    change_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_max_r,   out_max_nxt;

  logic             in_acc;
  prep_t            prep;
  logic [WIDE_W-1:0] wide;
  logic [REM0_W-1:0] rem0_w;
  logic             use_ratio;
  logic             ovf;
  logic             div_start;
  logic [OUT_W-1:0] quotient;
  div_stat_t        div_stat;
  logic [OUT_W-1:0] diff_sat;
  logic [OUT_W-1:0] quo_sat;
  logic [OUT_W-1:0] new_max;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  mrpc_prep u_prep (
    .clk           (clk),
    .load          (in_acc),
    .new_value     (in_new_value),
    .old_value     (in_old_value),
    .new_base      (in_new_base),
    .old_base      (in_old_base),
    .last_in_sweep (in_last_in_sweep),
    .prep          (prep)
  );

  // Split diff << FRAC_BITS: high part seeds the remainder, low word streams in
  always_comb begin
    wide      = WIDE_W'(prep.diff) << FRAC_BITS;
    rem0_w    = wide[WIDE_W-1:OUT_W];
    use_ratio = (prep.base != '0) && (prep.base >= BASE_W'(min_den_r));
    ovf       = (BASE_W+1)'(rem0_w) >= (BASE_W+1)'(prep.base);
    div_start = (state_r == S_OPER) && use_ratio && !ovf;
  end

  mrpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem0     (OUT_W'(rem0_w)),
    .stream   (wide[OUT_W-1:0]),
    .divisor  (prep.base),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Saturation of both change sources
  always_comb begin
    diff_sat = (prep.diff > DIFF_W'(SAT_LIMIT)) ? SAT_LIMIT : OUT_W'(prep.diff);
    quo_sat  = (quotient > SAT_LIMIT) ? SAT_LIMIT : quotient;
    new_max  = (change_r > max_r) ? change_r : max_r;
  end

  // Sequencer, running maximum and result register
  always_comb begin
    state_nxt     = state_r;
    min_den_nxt   = cfg_wr_en ? cfg_wr_data : min_den_r;
    max_nxt       = max_r;
    change_nxt    = change_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_max_nxt   = out_max_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_OPER;
        end
      end
      S_OPER: begin
        if (!use_ratio) begin
          change_nxt = diff_sat;
          state_nxt  = S_FIN;
        end else if (ovf) begin
          change_nxt = SAT_LIMIT;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          change_nxt = quo_sat;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (!prep.last) begin
          max_nxt   = new_max;
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_max_nxt   = new_max;
          out_valid_nxt = 1'b1;
          max_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_den_r   <= MIN_DEN_RESET;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_den_r   <= min_den_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    change_r  <= change_nxt;
    out_max_r <= out_max_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_max_change = out_max_r;

  // A new result only comes out of the update step
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result register loaded outside the update step");

  // No transaction is taken while the divider is iterating
  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  // A started division is busy in the next cycle
  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> div_stat.busy && state_r == S_DIV)
    else $error("divider did not start");

endmodule

[verif/tb_max_relative_pointwise_change_unit.sv]
// Testbench for max_relative_pointwise_change_unit: random and directed sweeps with bursty
// input, stalling output, floor register changes between phases, and a built-in predictor.
// Depends on mrpc_pkg and the unit's RTL only.
module tb_max_relative_pointwise_change_unit;
  import mrpc_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 40;     // above the divide latency
  localparam int HOLDOFF_TICKS = 400;

  typedef struct packed {
    logic [IN_W-1:0] new_value;
    logic [IN_W-1:0] old_value;
    logic [IN_W-1:0] new_base;
    logic [IN_W-1:0] old_base;
    logic            last;
  } sweep_point_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PERIODIC
  } rx_mode_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [IN_W-1:0]  in_new_value = '0;
  logic [IN_W-1:0]  in_old_value = '0;
  logic [IN_W-1:0]  in_new_base = '0;
  logic [IN_W-1:0]  in_old_base = '0;
  logic             in_last_in_sweep = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [OUT_W-1:0] out_max_change;

  // Pending points, expected sweep maxima, predictor state
  sweep_point_t     point_q[$];
  logic [OUT_W-1:0] max_change_q[$];
  logic [OUT_W-1:0] sweep_max = '0;
  logic [CFG_W-1:0] floor_reg = MIN_DEN_RESET;

  int       mismatches = 0;
  int       cycles = 0;
  bit       in_taken = 1'b0;
  int       burst_left = 1;
  int       gap_left = 0;
  bit       holdoff_req = 1'b0;
  int       holdoff_left = 0;
  int       mode_left = 0;
  rx_mode_t ready_mode = RDY_ALWAYS;
  logic [3:0] pattern_ctr = '0;

  max_relative_pointwise_change_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_new_value     (in_new_value),
    .in_old_value     (in_old_value),
    .in_new_base      (in_new_base),
    .in_old_base      (in_old_base),
    .in_last_in_sweep (in_last_in_sweep),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_max_change   (out_max_change)
  );

  // Clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Magnitude of a signed 32-bit value, exact (2^31 fits)
  function automatic logic [IN_W:0] magnitude(logic [IN_W-1:0] v);
    logic signed [IN_W:0] s;
    s = $signed(v);
    return (s < 0) ? (IN_W+1)'(-s) : (IN_W+1)'(s);
  endfunction

  // Pointwise change: |dv| / max(|nb|,|ob|), or |dv| under the floor, saturated
  function automatic logic [OUT_W-1:0] relative_change(sweep_point_t p, logic [CFG_W-1:0] flr);
    logic signed [IN_W:0] nv;
    logic signed [IN_W:0] ov;
    logic [IN_W:0]        diff;
    logic [IN_W:0]        nb;
    logic [IN_W:0]        ob;
    logic [IN_W:0]        base;
    logic [63:0]          change;
    nv = $signed(p.new_value);
    ov = $signed(p.old_value);
    diff = (nv >= ov) ? (IN_W+1)'(nv - ov) : (IN_W+1)'(ov - nv);
    nb = magnitude(p.new_base);
    ob = magnitude(p.old_base);
    base = (nb > ob) ? nb : ob;
    if (base == '0 || base < {2'b00, flr}) begin
      change = 64'(diff);
    end else begin
      change = (64'(diff) << FRAC_BITS) / 64'(base);
    end
    if (change > 64'(SAT_LIMIT)) begin
      change = 64'(SAT_LIMIT);
    end
    return change[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    $display("ERROR @%0t: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Input acceptance: update the running maximum, queue the result on the last point
  always @(posedge clk) begin
    logic [OUT_W-1:0] c;
    if (rst_n && in_valid && in_ready) begin
      c = relative_change(point_q[0], floor_reg);
      if (c > sweep_max) begin
        sweep_max = c;
      end
      if (point_q[0].last) begin
        max_change_q.push_back(sweep_max);
        sweep_max = '0;
      end
      void'(point_q.pop_front());
      in_taken = 1'b1;
    end
  end

  // Monitor: compare each accepted result with the oldest expected maximum
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (max_change_q.size() == 0) begin
        report_mismatch("unexpected max_change transaction", out_max_change, '0);
      end else begin
        want = max_change_q.pop_front();
        if (out_max_change !== want) begin
          report_mismatch("max_change", out_max_change, want);
        end
      end
    end
  end

  // Driver: bursts of transactions with random gaps, payload held until accepted
  always @(negedge clk) begin
    if (!(in_valid && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (point_q.size() > 0) begin
        in_new_value     <= point_q[0].new_value;
        in_old_value     <= point_q[0].old_value;
        in_new_base      <= point_q[0].new_base;
        in_old_base      <= point_q[0].old_base;
        in_last_in_sweep <= point_q[0].last;
        in_valid         <= 1'b1;
        in_taken = 1'b0;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: long hold-off on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (holdoff_req) begin
      holdoff_left = HOLDOFF_TICKS;
      holdoff_req = 1'b0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      pattern_ctr++;
      case (ready_mode)
        RDY_ALWAYS:   out_ready <= 1'b1;
        RDY_COIN:     out_ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
        default:      out_ready <= (pattern_ctr[2:0] == 3'd5) || pattern_ctr[3];
      endcase
    end
  end

  task automatic push_point(logic [IN_W-1:0] nv, logic [IN_W-1:0] ov,
                            logic [IN_W-1:0] nb, logic [IN_W-1:0] ob, logic last);
    sweep_point_t p;
    p.new_value = nv;
    p.old_value = ov;
    p.new_base  = nb;
    p.old_base  = ob;
    p.last      = last;
    point_q.push_back(p);
  endtask

  // Random word: full range, extremes, or a random width with random sign
  function automatic logic [IN_W-1:0] rand_word();
    logic [IN_W-1:0] v;
    int unsigned w;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      default: begin
        w = $urandom_range(0, 31);
        v = $urandom & (32'hFFFF_FFFF >> (32 - w));
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  // Base word: like a value, but often right around the current floor, or zero
  function automatic logic [IN_W-1:0] rand_base();
    logic [IN_W-1:0] v;
    case ($urandom_range(0, 4))
      0: begin
        v = {1'b0, floor_reg} + $urandom_range(0, 4) - 2;
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
      1: v = '0;
      default: v = rand_word();
    endcase
    return v;
  endfunction

  // Random sweeps, mostly short, sometimes long
  task automatic add_random_points(int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        push_point(rand_word(), rand_word(), rand_base(), rand_base(), k == len - 1);
      end
      n += len;
    end
  endtask

  // Wait until the unit is idle, then write the floor register
  task automatic write_floor(logic [CFG_W-1:0] v);
    while (point_q.size() != 0 || max_change_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    floor_reg = v;
  endtask

  // Stimulus and end of run
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Floor at its reset value: extremes, negative bases, saturation, a multi-point sweep
    push_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    push_point(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1'b1);
    push_point(32'h0000_8000, 32'hFFFF_8000, 32'hFFFF_0000, 32'h0000_8000, 1'b1);
    push_point(32'h0000_0000, 32'h0000_0005, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    push_point(32'h0000_0064, 32'h0000_0000, 32'h0001_0000, 32'h0002_0000, 1'b0);
    push_point(32'h0000_0007, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    push_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
    add_random_points(200);

    // Floor zero: a zero base still falls back to the plain difference
    write_floor('0);
    holdoff_req = 1'b1;
    push_point(32'h0001_2345, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    push_point(32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000, 1'b1);
    add_random_points(200);

    // Floor 1.0: base equal to the floor divides, one below does not
    write_floor(CFG_W'(32'h0001_0000));
    push_point(32'h0002_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b1);
    push_point(32'h0002_0000, 32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_0001, 1'b1);
    add_random_points(200);

    // Largest floor: only a base of 2^31 or 2^31 - 1 divides
    write_floor({CFG_W{1'b1}});
    push_point(32'h4000_0000, 32'hC000_0000, 32'h8000_0000, 32'h0000_0000, 1'b1);
    push_point(32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFE, 32'h8000_0002, 1'b1);
    push_point(32'h0000_1000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
    add_random_points(200);

    write_floor(CFG_W'($urandom_range(1, 1 << 24)));
    add_random_points(200);

    write_floor(CFG_W'($urandom));
    add_random_points(150);

    write_floor(CFG_W'(1));
    add_random_points(150);

    while (point_q.size() != 0 || max_change_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && max_change_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
